// ===== design/puf_pkg.sv =====
// shared types and constants for the parity union-find table
package puf_pkg;

   localparam int NODES      = 1024;
   localparam int NODE_W     = $clog2(NODES);
   localparam int REQ_DATA_W = ((2 * NODE_W + 7) / 8) * 8;
   localparam int REL_W      = 2;
   localparam int RSP_DATA_W = 8;

   // item kind carried on req_tuser
   localparam logic MODE_JOIN  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [REL_W-1:0] {
      REL_NONE = 2'd0,
      REL_SAME = 2'd1,
      REL_OPP  = 2'd2
   } rel_type;

   typedef logic [NODE_W-1:0] node_type;

   typedef struct packed {
      node_type link;
      logic     par;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_F1_RD,
      ST_F1_WALK,
      ST_F2_CHK,
      ST_F2_WALK,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic f1_adv;
      logic f1_root;
      logic f2_step;
      logic next_node;
      logic join_wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic link_eq_cur;
      logic cur_eq_root;
      logic link_eq_root;
      logic which;
      logic mode;
      logic rsp_busy;
   } stat_type;

endpackage

// ===== design/puf_datapath.sv =====
// link table, walk registers and result register of the parity union-find
module puf_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  puf_pkg::cmd_type                    cmd,
   output puf_pkg::stat_type                   stat,
   input  logic [puf_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [puf_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import puf_pkg::*;

   entry_type mem [NODES];
   entry_type rd_ff;

   node_type  node_a_ff, node_a_in;
   node_type  node_b_ff, node_b_in;
   logic      mode_ff, mode_in;
   logic      which_ff, which_in;
   node_type  cur_ff, cur_in;
   node_type  root_ff, root_in;
   node_type  ra_ff, ra_in;
   logic      acc_ff, acc_in;
   logic      pa_ff, pa_in;
   logic      p_ff, p_in;
   node_type  clr_ff, clr_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rel_type   rsp_rel_ff, rsp_rel_in;

   node_type  raddr;
   logic      we;
   node_type  waddr;
   entry_type wdata;
   rel_type   rel;

   always_comb begin
      node_a_in = node_a_ff;
      node_b_in = node_b_ff;
      mode_in   = mode_ff;
      which_in  = which_ff;
      cur_in    = cur_ff;
      root_in   = root_ff;
      ra_in     = ra_ff;
      acc_in    = acc_ff;
      pa_in     = pa_ff;
      p_in      = p_ff;
      if (cmd.accept) begin
         mode_in   = req_tuser;
         node_a_in = req_tdata[NODE_W-1:0];
         node_b_in = req_tdata[2*NODE_W-1:NODE_W];
         which_in  = 1'b0;
         cur_in    = req_tdata[NODE_W-1:0];
         acc_in    = 1'b0;
      end
      if (cmd.f1_adv) begin
         acc_in = acc_ff ^ rd_ff.par;
         cur_in = rd_ff.link;
      end
      if (cmd.f1_root) begin
         root_in = cur_ff;
         p_in    = acc_ff;
         cur_in  = which_ff ? node_b_ff : node_a_ff;
      end
      if (cmd.f2_step) begin
         p_in   = p_ff ^ rd_ff.par;
         cur_in = rd_ff.link;
      end
      if (cmd.next_node) begin
         ra_in    = root_ff;
         pa_in    = acc_ff;
         which_in = 1'b1;
         cur_in   = node_b_ff;
         acc_in   = 1'b0;
      end
   end

   // read the next link straight from the data just returned while walking
   assign raddr = (cmd.f1_adv || cmd.f2_step) ? rd_ff.link : cur_ff;

   always_comb begin
      we    = 1'b0;
      waddr = cur_ff;
      wdata = '{link: root_ff, par: p_ff};
      priority if (cmd.clear_wr) begin
         we    = 1'b1;
         waddr = clr_ff;
         wdata = '{link: clr_ff, par: 1'b0};
      end else if (cmd.f2_step) begin
         we    = 1'b1;
      end else if (cmd.join_wr && (ra_ff != root_ff)) begin
         we    = 1'b1;
         waddr = ra_ff;
         wdata = '{link: root_ff, par: ~(pa_ff ^ acc_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   always_comb begin
      if (ra_ff != root_ff) begin
         rel = REL_NONE;
      end else if (pa_ff ^ acc_ff) begin
         rel = REL_OPP;
      end else begin
         rel = REL_SAME;
      end
   end

   always_comb begin
      clr_in       = cmd.clear_wr ? clr_ff + 1'b1 : clr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rel_in   = rsp_rel_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_rel_in   = rel;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_a_ff  <= node_a_in;
      node_b_ff  <= node_b_in;
      mode_ff    <= mode_in;
      which_ff   <= which_in;
      cur_ff     <= cur_in;
      root_ff    <= root_in;
      ra_ff      <= ra_in;
      acc_ff     <= acc_in;
      pa_ff      <= pa_in;
      p_ff       <= p_in;
      rsp_rel_ff <= rsp_rel_in;
   end

   assign stat.clr_last     = (clr_ff == node_type'(NODES - 1));
   assign stat.link_eq_cur  = (rd_ff.link == cur_ff);
   assign stat.cur_eq_root  = (cur_ff == root_ff);
   assign stat.link_eq_root = (rd_ff.link == root_ff);
   assign stat.which        = which_ff;
   assign stat.mode         = mode_ff;
   assign stat.rsp_busy     = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_rel_ff);

endmodule

// ===== design/puf_ctrl.sv =====
// sequencer for clearing, root walks, path compression and joins
module puf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  puf_pkg::stat_type  stat,
   output puf_pkg::cmd_type   cmd
);
   import puf_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_F1_RD;
         end
         ST_F1_RD: begin
            state_in = ST_F1_WALK;
         end
         ST_F1_WALK: begin
            if (stat.link_eq_cur) state_in = ST_F2_CHK;
         end
         ST_F2_CHK: begin
            state_in = stat.cur_eq_root ? ST_FIN : ST_F2_WALK;
         end
         ST_F2_WALK: begin
            if (stat.link_eq_root) state_in = ST_FIN;
         end
         ST_FIN: begin
            priority if (!stat.which) begin
               state_in = ST_F1_RD;
            end else if (stat.mode == MODE_JOIN) begin
               state_in = ST_IDLE;
            end else if (!stat.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_F1_RD: begin
         end
         ST_F1_WALK: begin
            if (stat.link_eq_cur) begin
               cmd.f1_root = 1'b1;
            end else begin
               cmd.f1_adv  = 1'b1;
            end
         end
         ST_F2_CHK: begin
         end
         ST_F2_WALK: begin
            cmd.f2_step = 1'b1;
         end
         ST_FIN: begin
            priority if (!stat.which) begin
               cmd.next_node = 1'b1;
            end else if (stat.mode == MODE_JOIN) begin
               cmd.join_wr = 1'b1;
            end else begin
               cmd.rsp_load = !stat.rsp_busy;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/parity_union_find_top.sv =====
// top level of the parity union-find table
// Disjoint-set table of 1024 nodes with a parent link and a parity bit per
// node. After reset the block clears the link table (one entry a cycle)
// before it takes its first item. A join item (tuser 0) hangs the root of
// node_a under the root of node_b so that the two nodes have opposite
// parity, and gives no result; a query item (tuser 1) returns 0 for
// unconnected, 1 for same parity, 2 for opposite parity. Items are handled
// one at a time; the root walks and the path compression of both nodes
// share the single read port of the link table. A query result sits in an
// output register, so the next item is taken while it waits.
module parity_union_find_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [puf_pkg::REQ_DATA_W-1:0]     req_tdata,  // node_a, node_b
   input  logic                               req_tuser,  // mode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [puf_pkg::RSP_DATA_W-1:0]     rsp_tdata   // relation
);
   import puf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   puf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   puf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the parity union-find table: predictor, stimulus and result checks
module tb_top;
   import puf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 64;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // node_a, node_b
   logic                  req_tuser  = MODE_JOIN;   // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // relation

   // predictor copy of the link table
   node_type link_mem [NODES];
   bit       par_mem  [NODES];
   rel_type  pending_rel [$];

   int error_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   parity_union_find_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // walk to the root, then relink every node on the path with its parity to the root
   function automatic node_type find_root_pred(input node_type n, output bit par);
      node_type cur;
      node_type root;
      node_type nxt;
      bit       acc;
      bit       p;
      bit       old;
      int       steps;
      cur = n;
      acc = 1'b0;
      steps = 0;
      while (link_mem[cur] != cur && steps < NODES) begin
         acc ^= par_mem[cur];
         cur = link_mem[cur];
         steps++;
      end
      root = cur;
      cur = n;
      p = acc;
      steps = 0;
      while (cur != root && steps < NODES) begin
         nxt = link_mem[cur];
         old = par_mem[cur];
         link_mem[cur] = root;
         par_mem[cur] = p;
         p ^= old;
         cur = nxt;
         steps++;
      end
      par = acc;
      return root;
   endfunction

   function automatic void predict_item(input logic mode, input node_type a, input node_type b);
      node_type ra;
      node_type rb;
      bit       pa;
      bit       pb;
      ra = find_root_pred(a, pa);
      rb = find_root_pred(b, pb);
      if (mode == MODE_JOIN) begin
         if (ra != rb) begin
            link_mem[ra] = rb;
            par_mem[ra] = pa ^ pb ^ 1'b1;
         end
      end else if (ra != rb) begin
         pending_rel.push_back(REL_NONE);
      end else if (pa ^ pb) begin
         pending_rel.push_back(REL_OPP);
      end else begin
         pending_rel.push_back(REL_SAME);
      end
   endfunction

   // valid stays high between back-to-back items, dropped only for an idle gap
   task automatic send_item(input logic mode, input node_type a, input node_type b);
      logic [REQ_DATA_W-1:0] word;
      word = '0;
      word[NODE_W-1:0] = a;
      word[2*NODE_W-1:NODE_W] = b;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      req_tuser <= mode;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(mode, a, b);
   endtask

   task automatic wait_results_drained;
      req_tvalid <= 1'b0;
      while (pending_rel.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      rel_type want_rel;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rel.size() == 0) begin
            report_error($sformatf("unexpected result, relation %0d", rsp_tdata[REL_W-1:0]));
         end else begin
            want_rel = pending_rel.pop_front();
            if (rsp_tdata[REL_W-1:0] !== want_rel)
               report_error($sformatf("relation %0d, expected %0d",
                                      rsp_tdata[REL_W-1:0], want_rel));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_edge_nodes;
      send_item(MODE_QUERY, 10'd0, 10'd0);
      send_item(MODE_QUERY, 10'd0, 10'd1023);
      send_item(MODE_JOIN, 10'd0, 10'd1023);
      send_item(MODE_QUERY, 10'd0, 10'd1023);
      send_item(MODE_QUERY, 10'd1023, 10'd0);
      send_item(MODE_QUERY, 10'd682, 10'd341);
   endtask

   // same node twice and joins of nodes already connected
   task automatic test_join_rules;
      send_item(MODE_JOIN, 10'd5, 10'd5);
      send_item(MODE_QUERY, 10'd5, 10'd5);
      send_item(MODE_JOIN, 10'd1, 10'd1023);
      send_item(MODE_QUERY, 10'd0, 10'd1);
      send_item(MODE_JOIN, 10'd0, 10'd1);
      send_item(MODE_QUERY, 10'd1, 10'd0);
      send_item(MODE_QUERY, 10'd1, 10'd5);
   endtask

   // each join hangs the old root under the next node, so the chain deepens
   task automatic test_deep_chain;
      for (int k = 100; k < 111; k++)
         send_item(MODE_JOIN, node_type'(k), node_type'(k + 1));
      send_item(MODE_QUERY, 10'd100, 10'd111);
      send_item(MODE_QUERY, 10'd101, 10'd104);
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      int       base;
      logic     mode;
      node_type a;
      node_type b;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         // nodes mostly from a narrow window so trees merge and deepen
         if (i % 40 == 0) base = $urandom_range(NODES - 64);
         mode = ($urandom_range(99) < 40) ? MODE_QUERY : MODE_JOIN;
         a = ($urandom_range(99) < 20) ? node_type'($urandom) :
                                         node_type'(base + $urandom_range(63));
         b = ($urandom_range(99) < 20) ? node_type'($urandom) :
                                         node_type'(base + $urandom_range(63));
         if ($urandom_range(99) < 5) b = a;
         send_item(mode, a, b);
      end
   endtask

   initial begin
      for (int i = 0; i < NODES; i++) begin
         link_mem[i] = node_type'(i);
         par_mem[i] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_nodes();
      test_join_rules();
      rsp_stall_pct = 30;
      test_deep_chain();
      wait_results_drained();

      test_random_traffic(230, 0, 0);
      wait_results_drained();
      test_random_traffic(230, 70, 0);
      wait_results_drained();
      test_random_traffic(230, 0, 70);
      wait_results_drained();
      test_random_traffic(230, 27, 27);
      wait_results_drained();

      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
